FILE: design/ccrvb_pkg.sv
// shared types, register map codes and conversion functions for the clock register view bridge
package ccrvb_pkg;

   localparam int IMAGE_DEPTH_DEF = 64;

   // register map indices
   localparam logic [5:0] IDX_SECONDS   = 6'd0;
   localparam logic [5:0] IDX_MINUTES   = 6'd2;
   localparam logic [5:0] IDX_HOURS     = 6'd4;
   localparam logic [5:0] IDX_DATE      = 6'd7;
   localparam logic [5:0] IDX_MONTH     = 6'd8;
   localparam logic [5:0] IDX_YEAR      = 6'd9;
   localparam logic [5:0] IDX_HALT      = 6'd11;
   localparam logic [5:0] IDX_STATUS    = 6'd13;
   localparam logic [5:0] IDX_RAM_START = 6'd14;
   localparam logic [5:0] IDX_LAST      = 6'd63;

   // chip byte addresses
   localparam logic [5:0] CHIP_SECONDS  = 6'd0;
   localparam logic [5:0] CHIP_MINUTES  = 6'd1;
   localparam logic [5:0] CHIP_HOURS    = 6'd2;
   localparam logic [5:0] CHIP_DATE     = 6'd4;
   localparam logic [5:0] CHIP_MONTH    = 6'd5;
   localparam logic [5:0] CHIP_YEAR     = 6'd6;
   localparam logic [5:0] RAM_OFFSET    = 6'd6;  // view index 14 lands on chip byte 8

   localparam logic [7:0] MASK_7F       = 8'h7f;
   localparam logic [7:0] MASK_3F       = 8'h3f;
   localparam logic [7:0] MASK_1F       = 8'h1f;
   localparam logic [7:0] MASK_FF       = 8'hff;
   localparam logic [7:0] HALT_BIT      = 8'h80;
   localparam logic [7:0] STATUS_VALUE  = 8'h80;

   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   typedef struct packed {
      logic       timed;
      logic       halt;
      logic       status;
      logic       ram;
      logic [5:0] chip;
      logic [7:0] mask;
   } decode_type;

   typedef struct packed {
      logic capture;
      logic lookup;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

   function automatic decode_type decode_index(input logic [5:0] idx);
      decode_type d;
      d = '0;
      case (idx)
         IDX_SECONDS: begin d.timed = 1'b1; d.chip = CHIP_SECONDS; d.mask = MASK_7F; end
         IDX_MINUTES: begin d.timed = 1'b1; d.chip = CHIP_MINUTES; d.mask = MASK_7F; end
         IDX_HOURS:   begin d.timed = 1'b1; d.chip = CHIP_HOURS;   d.mask = MASK_3F; end
         IDX_DATE:    begin d.timed = 1'b1; d.chip = CHIP_DATE;    d.mask = MASK_3F; end
         IDX_MONTH:   begin d.timed = 1'b1; d.chip = CHIP_MONTH;   d.mask = MASK_1F; end
         IDX_YEAR:    begin d.timed = 1'b1; d.chip = CHIP_YEAR;    d.mask = MASK_FF; end
         IDX_HALT:    begin d.halt = 1'b1; d.chip = CHIP_SECONDS; end
         IDX_STATUS:  begin d.status = 1'b1; end
         default: begin
            if (idx inside {[IDX_RAM_START:IDX_LAST]}) begin
               d.ram  = 1'b1;
               d.chip = idx - RAM_OFFSET;
            end
         end
      endcase
      return d;
   endfunction

   // divide by ten through a reciprocal multiply, exact for any byte
   function automatic logic [7:0] to_bcd(input logic [7:0] v);
      logic [15:0] prod;
      logic [4:0]  q;
      logic [7:0]  r;
      prod = 16'(v) * 16'd205;
      q    = prod[15:11];
      r    = v - 8'(q) * 8'd10;
      return {q[3:0], r[3:0]};
   endfunction

   function automatic logic [7:0] from_bcd(input logic [7:0] b);
      return {4'b0, b[3:0]} + 8'(b[7:4]) * 8'd10;
   endfunction

endpackage

FILE: design/ccrvb_ctrl.sv
// controller state machine sequencing capture, image lookup and commit of each access
module ccrvb_ctrl
   import ccrvb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_LOOKUP = 2'd1;
   localparam logic [1:0] ST_EXEC   = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_tready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
            if (req_tvalid) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = ST_EXEC;
         end
         ST_EXEC: begin
            // hold here while the previous result is still unclaimed
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

`ifndef SYNTHESIS
   a_accept_to_lookup: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_LOOKUP))
      else $error("accepted beat did not start a lookup");

   a_lookup_to_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOKUP) |=> (state_ff == ST_EXEC))
      else $error("lookup not followed by execute");

   a_commit_needs_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> status.out_free)
      else $error("commit while result slot occupied");
`endif

endmodule

FILE: design/ccrvb_datapath.sv
// datapath: access registers, chip image memory with valid bits, bcd conversion, result register
module ccrvb_datapath
   import ccrvb_pkg::*;
#(
   parameter int IMAGE_DEPTH = IMAGE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic        req_cmd,
   input  logic [5:0]  req_index,
   input  logic [7:0]  req_wdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_data
);

   localparam int AW = $clog2(IMAGE_DEPTH);

   logic             cmd_ff;
   logic [5:0]       idx_ff;
   logic [7:0]       wdata_ff;
   logic [7:0]       bcd_ff;
   logic [7:0]       mem_ff [IMAGE_DEPTH];
   logic [IMAGE_DEPTH-1:0] valid_ff;
   logic [7:0]       rd_data_ff;
   logic             rd_valid_ff;
   logic [7:0]       rsp_data_ff;
   logic             rsp_valid_ff;

   decode_type       dec;
   logic [AW-1:0]    addr;
   logic [7:0]       old_byte;
   logic [7:0]       new_byte;
   logic [7:0]       rd_byte;
   logic             wr_en;

   assign dec      = decode_index(idx_ff);
   assign addr     = AW'(dec.chip);
   assign old_byte = rd_valid_ff ? rd_data_ff : 8'h00;

   always_comb begin
      new_byte = wdata_ff;
      rd_byte  = 8'h00;
      if (dec.timed) begin
         new_byte = bcd_ff & dec.mask;
         if (idx_ff == IDX_SECONDS) new_byte = (old_byte & HALT_BIT) | (bcd_ff & dec.mask);
         rd_byte  = from_bcd(old_byte & dec.mask);
      end else if (dec.halt) begin
         new_byte = (old_byte & MASK_7F) | (wdata_ff & HALT_BIT);
      end else if (dec.status) begin
         rd_byte  = STATUS_VALUE;
      end else if (dec.ram) begin
         rd_byte  = old_byte;
      end
      if (cmd_ff == CMD_WRITE) rd_byte = 8'h00;
   end

   assign wr_en = cmd.commit && (cmd_ff == CMD_WRITE) && (dec.timed || dec.halt || dec.ram);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff   <= req_cmd;
         idx_ff   <= req_index;
         wdata_ff <= req_wdata;
      end
      if (cmd.lookup) begin
         bcd_ff      <= to_bcd(wdata_ff);
         rd_data_ff  <= mem_ff[addr];
         rd_valid_ff <= valid_ff[addr];
      end
      if (wr_en) mem_ff[addr] <= new_byte;
      if (cmd.commit) rsp_data_ff <= rd_byte;
   end

   // valid bits stand in for clearing the image at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (wr_en) valid_ff[addr] <= 1'b1;
         if (cmd.commit)      rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;

`ifndef SYNTHESIS
   a_write_returns_zero: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && cmd_ff == CMD_WRITE) |=> (rsp_data == 8'h00))
      else $error("write beat returned nonzero data");

   a_commit_raises_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_tvalid)
      else $error("commit did not present a result");

   a_status_read: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && cmd_ff == CMD_READ && idx_ff == IDX_STATUS) |=>
      (rsp_data == STATUS_VALUE))
      else $error("status register read wrong");
`endif

endmodule

FILE: design/cmos_clock_register_view_bridge.sv
// top level of the binary clock register view over a bcd clock chip image
//
//  channel | direction | handshake             | contents
//  req     | in        | req_tvalid/req_tready | tuser: cmd; tdata: reg_index, write_data
//  rsp     | out       | rsp_tvalid/rsp_tready | tdata: read_data
//
// each access steps through capture, image read, then convert and commit
// one access is in flight at a time; the image memory read precedes its write-back
// a finished result sits in an output register while the next beat is accepted
// a stalled result holds the following access in its commit cycle
// synchronous reset clears the image valid bits at once; no clearing pass
module cmos_clock_register_view_bridge
   import ccrvb_pkg::*;
#(
   parameter int IMAGE_DEPTH = IMAGE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [5:0] reg_index, [13:6] write_data, [15:14] zero
   input  logic        req_tuser,   // [0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [7:0] read_data
);

   cmd_type    cmd;
   status_type status;

   ccrvb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ccrvb_datapath #(
      .IMAGE_DEPTH (IMAGE_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_cmd    (req_tuser),
      .req_index  (req_tdata[5:0]),
      .req_wdata  (req_tdata[13:6]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_tdata)
   );

endmodule

FILE: test/ccrvb_view_checker.sv
// checker for the clock register view bridge: tracks the chip image and compares read bytes
module ccrvb_view_checker
   import ccrvb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,   // [5:0] reg_index, [13:6] write_data, [15:14] zero
   input  logic        req_tuser,   // [0] cmd
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // [7:0] read_data
   output int          mismatch_count,
   output int          reads_in_flight
);
   timeunit 1ns;
   timeprecision 1ps;

   // view index 14 lands on chip byte 8
   localparam int RAM_CHIP_BASE = 8;

   logic [7:0] chip_bytes [IMAGE_DEPTH_DEF];
   logic [7:0] expected_bytes [$];
   int errors = 0;

   function automatic logic [7:0] bin_to_bcd(input logic [7:0] v);
      int u;
      u = int'(v);
      return 8'((u % 10) + ((u / 10) << 4));
   endfunction

   function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
      return 8'(int'(b[3:0]) + 10 * int'(b[7:4]));
   endfunction

   // applies one access to the image copy and returns the byte the bus should see
   function automatic logic [7:0] apply_access(input logic cmd, input logic [5:0] idx,
                                               input logic [7:0] wdata);
      logic       timed;
      logic [5:0] chip;
      logic [7:0] mask;
      logic [7:0] nv;
      int         ram_addr;
      timed = 1'b1;
      chip  = CHIP_SECONDS;
      mask  = 8'h00;
      case (idx)
         IDX_SECONDS: begin chip = CHIP_SECONDS; mask = MASK_7F; end
         IDX_MINUTES: begin chip = CHIP_MINUTES; mask = MASK_7F; end
         IDX_HOURS:   begin chip = CHIP_HOURS;   mask = MASK_3F; end
         IDX_DATE:    begin chip = CHIP_DATE;    mask = MASK_3F; end
         IDX_MONTH:   begin chip = CHIP_MONTH;   mask = MASK_1F; end
         IDX_YEAR:    begin chip = CHIP_YEAR;    mask = MASK_FF; end
         default:     timed = 1'b0;
      endcase
      ram_addr = int'(idx) - int'(IDX_RAM_START) + RAM_CHIP_BASE;
      if (cmd == CMD_READ) begin
         if (timed) return bcd_to_bin(chip_bytes[chip] & mask);
         if (idx == IDX_STATUS) return STATUS_VALUE;
         if (idx >= IDX_RAM_START && ram_addr < IMAGE_DEPTH_DEF) return chip_bytes[ram_addr];
         return 8'h00;
      end
      if (timed) begin
         nv = bin_to_bcd(wdata) & mask;
         // seconds write keeps the halt bit
         if (idx == IDX_SECONDS) nv = nv | (chip_bytes[CHIP_SECONDS] & HALT_BIT);
         chip_bytes[chip] = nv;
      end else if (idx == IDX_HALT) begin
         chip_bytes[CHIP_SECONDS] = (chip_bytes[CHIP_SECONDS] & ~HALT_BIT) | (wdata & HALT_BIT);
      end else if (idx >= IDX_RAM_START && ram_addr < IMAGE_DEPTH_DEF) begin
         chip_bytes[ram_addr] = wdata;
      end
      return 8'h00;
   endfunction

   always @(posedge clock) begin : track
      logic [7:0] want;
      int         i;
      if (reset) begin
         for (i = 0; i < IMAGE_DEPTH_DEF; i++) chip_bytes[i] = 8'h00;
         expected_bytes.delete();
      end else begin
         // result first: a beat accepted at this edge cannot belong to a request of the same edge
         if (rsp_tvalid && rsp_tready) begin
            if (expected_bytes.size() == 0) begin
               $error("read_data: no access pending, got %02h", rsp_tdata);
               errors++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_tdata !== want) begin
                  $error("read_data: expected %02h, actual %02h", want, rsp_tdata);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_bytes.push_back(apply_access(req_tuser, req_tdata[5:0], req_tdata[13:6]));
      end
      mismatch_count  <= errors;
      reads_in_flight <= expected_bytes.size();
   end

endmodule

FILE: test/cmos_clock_register_view_bridge_test.sv
// top of the clock register view bridge testbench: stimulus, stalls, watchdog and verdict
module cmos_clock_register_view_bridge_test;
   import ccrvb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT   = 2000;
   localparam int RANDOM_ITEMS = 1950;

   localparam logic [5:0] TIMED_INDEX [6] = '{IDX_SECONDS, IDX_MINUTES, IDX_HOURS,
                                             IDX_DATE, IDX_MONTH, IDX_YEAR};
   // low indices with no function: read zero, writes dropped
   localparam logic [5:0] UNUSED_LOW [6] = '{6'd1, 6'd3, 6'd5, 6'd6, 6'd10, 6'd12};

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [15:0] req_tdata  = '0;
   logic        req_tuser  = 1'b0;
   logic        rsp_tready = 1'b0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [7:0]  rsp_tdata;

   int mismatch_count;
   int reads_in_flight;
   bit back_to_back = 1'b0;

   always #4 clock = ~clock;

   cmos_clock_register_view_bridge dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   ccrvb_view_checker view_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .mismatch_count  (mismatch_count),
      .reads_in_flight (reads_in_flight)
   );

   function automatic int draw_wait();
      return back_to_back ? 0 : $urandom_range(0, 16);
   endfunction

   function automatic logic [5:0] pick_index();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 45) return TIMED_INDEX[$urandom_range(0, 5)];
      if (sel < 55) return IDX_HALT;
      if (sel < 60) return IDX_STATUS;
      if (sel < 70) return UNUSED_LOW[$urandom_range(0, 5)];
      return 6'($urandom_range(IDX_RAM_START, IDX_LAST));
   endfunction

   task automatic send_access(input logic cmd, input logic [5:0] idx, input logic [7:0] data);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {2'b00, data, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // result side: random stall before each beat, skipped while back_to_back is set
   initial begin : result_sink
      int n;
      wait (!reset);
      forever begin
         n = draw_wait();
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle = 0;
         else idle++;
      end
      $display("cmos_clock_register_view_bridge: mismatch");
      $finish;
   end

   initial begin : stimulus
      logic [7:0] data;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: halt bit handling, conversion extremes, status, dead indices, ram ends
      send_access(CMD_READ,  IDX_SECONDS,   8'h00);
      send_access(CMD_WRITE, IDX_SECONDS,   8'd99);
      send_access(CMD_WRITE, IDX_HALT,      8'hff);
      send_access(CMD_READ,  IDX_SECONDS,   8'h00);
      send_access(CMD_WRITE, IDX_SECONDS,   8'd0);
      send_access(CMD_READ,  IDX_HALT,      8'h00);
      send_access(CMD_WRITE, IDX_HALT,      8'h7f);
      send_access(CMD_WRITE, IDX_MINUTES,   8'd255);
      send_access(CMD_READ,  IDX_MINUTES,   8'h00);
      send_access(CMD_WRITE, IDX_HOURS,     8'd59);
      send_access(CMD_READ,  IDX_HOURS,     8'h00);
      send_access(CMD_WRITE, IDX_DATE,      8'd165);
      send_access(CMD_READ,  IDX_DATE,      8'h00);
      send_access(CMD_WRITE, IDX_MONTH,     8'd12);
      send_access(CMD_READ,  IDX_MONTH,     8'h00);
      // 159 leaves a non-bcd upper nibble in the year byte
      send_access(CMD_WRITE, IDX_YEAR,      8'd159);
      send_access(CMD_READ,  IDX_YEAR,      8'hff);
      send_access(CMD_WRITE, IDX_STATUS,    8'h00);
      send_access(CMD_READ,  IDX_STATUS,    8'h00);
      send_access(CMD_WRITE, UNUSED_LOW[0], 8'hff);
      send_access(CMD_READ,  UNUSED_LOW[0], 8'h00);
      send_access(CMD_WRITE, IDX_RAM_START, 8'hff);
      send_access(CMD_READ,  IDX_RAM_START, 8'h00);
      send_access(CMD_WRITE, IDX_LAST,      8'ha5);
      send_access(CMD_READ,  IDX_LAST,      8'h00);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if ($urandom_range(0, 99) == 0) back_to_back = ~back_to_back;
         data = $urandom_range(0, 1) ? 8'($urandom_range(0, 99)) : 8'($urandom_range(0, 255));
         send_access($urandom_range(0, 1) ? CMD_WRITE : CMD_READ, pick_index(), data);
      end
      req_tvalid <= 1'b0;

      // the count is registered and lags the queue, so step the clock before polling it
      @(posedge clock);
      while (reads_in_flight != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("cmos_clock_register_view_bridge: match");
      end else begin
         $display("cmos_clock_register_view_bridge: mismatch");
      end
      $finish;
   end

endmodule

FILE: cmos_clock_register_view_bridge.f
design/ccrvb_pkg.sv
design/ccrvb_ctrl.sv
design/ccrvb_datapath.sv
design/cmos_clock_register_view_bridge.sv
test/ccrvb_view_checker.sv
test/cmos_clock_register_view_bridge_test.sv
